FILE: hw/rtl/wrmt_pkg.sv
// ----------------------------------------------------------------------------
// wrmt_pkg: shared types and codes for the watchpoint range match table
// Command and status codes, the entry record held by each cell, the item
// broadcast to the cells and the token that walks the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package wrmt_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_ENABLE = 3'd2;
    localparam logic [2:0] CMD_CHECK  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Stored watchpoint, without its valid bit
    typedef struct packed {
        logic [31:0] ident;
        logic [7:0]  space;
        logic [31:0] start;
        logic [31:0] length;
        logic [1:0]  mask;
        logic        enabled;
        logic [31:0] hits;
    } entry_data_t;

    // Watchpoint as seen by the neighbouring cell
    typedef struct packed {
        logic        valid;
        entry_data_t data;
    } entry_t;

    // Item held by the top level and broadcast to all cells
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  space;
        logic [31:0] address;
        logic [31:0] length;      // already forced to at least one
        logic [1:0]  access_mask;
        logic        access_is_write;
        logic [31:0] entry_id;
        logic        enable_value;
        logic [31:0] next_ident;
    } item_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        found;
        logic        inserted;
        logic [31:0] rid;
        logic [31:0] hits;
    } token_t;

    // Finished result
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rid;
        logic [31:0] hits;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wrmt_cell.sv
// ----------------------------------------------------------------------------
// wrmt_cell: one watchpoint slot of the match chain
// Holds one entry, acts on the broadcast item while the token sits here and
// hands the token to the next cell. On remove it pulls in its right
// neighbour's entry so the table stays packed.
// ----------------------------------------------------------------------------
`default_nettype none

module wrmt_cell
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wrmt_pkg::item_t       item,
    input  wrmt_pkg::token_t      tok_in,
    input  wrmt_pkg::entry_t      nbr_entry,
    output wrmt_pkg::token_t      tok_out,
    output wrmt_pkg::entry_t      entry
);

    logic                  valid_reg;
    logic                  valid_next;
    wrmt_pkg::entry_data_t data_reg;
    wrmt_pkg::entry_data_t data_next;
    wrmt_pkg::token_t      tok_reg;
    wrmt_pkg::token_t      tok_next;

    logic        id_match;
    logic        dup_match;
    logic [31:0] offset;
    logic        range_hit;
    logic        kind_ok;
    logic        check_hit;
    logic [31:0] hits_inc;

    // Comparisons against the broadcast item
    assign id_match  = valid_reg && (data_reg.ident == item.entry_id);
    assign dup_match = valid_reg && (data_reg.space == item.space)
                       && (data_reg.start == item.address)
                       && (data_reg.length == item.length)
                       && (data_reg.mask == item.access_mask);
    assign offset    = item.address - data_reg.start;
    assign range_hit = (item.address >= data_reg.start) && (offset < data_reg.length);
    assign kind_ok   = item.access_is_write ? data_reg.mask[1] : data_reg.mask[0];
    assign check_hit = valid_reg && data_reg.enabled && (data_reg.space == item.space)
                       && kind_ok && range_hit;
    assign hits_inc  = (data_reg.hits == 32'hFFFF_FFFF) ? data_reg.hits
                                                        : data_reg.hits + 32'd1;

    // Command action while the token is here
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        tok_next   = tok_in;
        if (tok_in.active)
        begin
            case (item.command)
                wrmt_pkg::CMD_ADD:
                begin
                    if (!tok_in.found)
                    begin
                        if (dup_match)
                        begin
                            tok_next.found = 1'b1;
                            tok_next.rid   = data_reg.ident;
                        end
                        else if (!valid_reg && (item.next_ident != 32'd0))
                        begin
                            // first free slot: append here
                            valid_next        = 1'b1;
                            data_next.ident   = item.next_ident;
                            data_next.space   = item.space;
                            data_next.start   = item.address;
                            data_next.length  = item.length;
                            data_next.mask    = item.access_mask;
                            data_next.enabled = 1'b1;
                            data_next.hits    = 32'd0;
                            tok_next.found    = 1'b1;
                            tok_next.inserted = 1'b1;
                            tok_next.rid      = item.next_ident;
                        end
                    end
                end
                wrmt_pkg::CMD_REMOVE:
                begin
                    // from the removed slot onwards every cell takes its neighbour
                    if (tok_in.found || id_match)
                    begin
                        valid_next     = nbr_entry.valid;
                        data_next      = nbr_entry.data;
                        tok_next.found = 1'b1;
                    end
                end
                wrmt_pkg::CMD_ENABLE:
                begin
                    if (!tok_in.found && id_match)
                    begin
                        data_next.enabled = item.enable_value;
                        tok_next.found    = 1'b1;
                    end
                end
                wrmt_pkg::CMD_CHECK:
                begin
                    if (!tok_in.found && check_hit)
                    begin
                        data_next.hits = hits_inc;
                        tok_next.found = 1'b1;
                        tok_next.rid   = data_reg.ident;
                        tok_next.hits  = hits_inc;
                    end
                end
                wrmt_pkg::CMD_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign tok_out     = tok_reg;
    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/watchpoint_range_match_table.sv
// ----------------------------------------------------------------------------
// watchpoint_range_match_table: ordered table of memory watchpoints
// Add, remove, enable, access check and clear commands over a chain of
// watchpoint cells kept packed in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command item with its fields.
//   Output channel (out_valid/out_ready) gives one result item per command:
//   status, result_id and match_count.
//   Each command walks a token down a chain of TABLE_ENTRIES cells, one cell
//   a cycle; for add, enable and check the first cell that qualifies claims
//   the command. The result is registered from the token leaving the last
//   cell, so the length of the chain sets how long a command takes; the next
//   item is taken only after that result. One command is in flight at a time.
//   The finished result sits in an output register, so a new item is taken
//   while it waits. If the receiver still stalls when the next result is
//   ready, that result is parked and no further item is taken until it moves.
//   Reset empties the table at once (valid bits cleared) and restarts ids at
//   one; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module watchpoint_range_match_table
#(
    parameter int TABLE_ENTRIES = wrmt_pkg::TABLE_ENTRIES_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [2:0]  command,
    input  wire  [7:0]  space,
    input  wire  [31:0] address,
    input  wire  [31:0] length,
    input  wire  [1:0]  access_mask,
    input  wire         access_is_write,
    input  wire  [31:0] entry_id,
    input  wire         enable_value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [31:0] result_id,
    output logic [31:0] match_count
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    wrmt_pkg::item_t   item_reg;
    logic [31:0]       next_ident_reg;
    logic [31:0]       next_ident_next;
    logic              start_reg;
    wrmt_pkg::result_t pend_reg;
    wrmt_pkg::result_t out_reg;
    logic              out_valid_reg;

    wrmt_pkg::item_t   item_bc;
    wrmt_pkg::token_t  tok_w   [TABLE_ENTRIES+1];
    wrmt_pkg::entry_t  entry_w [TABLE_ENTRIES+1];
    wrmt_pkg::result_t fin;

    logic accept;
    logic finish;
    logic out_free;
    logic load_out;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (state_reg == S_WALK) && tok_w[TABLE_ENTRIES].active;
    assign load_out = (finish || (state_reg == S_DRAIN)) && out_free;

    // Broadcast item with the current id counter
    always_comb
    begin
        item_bc            = item_reg;
        item_bc.next_ident = next_ident_reg;
    end

    // Token injected into the first cell
    always_comb
    begin
        tok_w[0]        = '0;
        tok_w[0].active = start_reg;
    end

    // Past the last cell there is only an empty slot
    assign entry_w[TABLE_ENTRIES] = '0;

    // Cell chain
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        wrmt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .item      (item_bc),
            .tok_in    (tok_w[i]),
            .nbr_entry (entry_w[i+1]),
            .tok_out   (tok_w[i+1]),
            .entry     (entry_w[i])
        );
    end

    // Result from the token leaving the chain
    always_comb
    begin
        fin.rid  = tok_w[TABLE_ENTRIES].rid;
        fin.hits = tok_w[TABLE_ENTRIES].hits;
        if (tok_w[TABLE_ENTRIES].found || (item_reg.command == wrmt_pkg::CMD_CLEAR))
        begin
            fin.status = wrmt_pkg::ST_DONE;
        end
        else if (item_reg.command == wrmt_pkg::CMD_ADD)
        begin
            fin.status = wrmt_pkg::ST_FULL;
        end
        else
        begin
            fin.status = wrmt_pkg::ST_MISS;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (finish)
                begin
                    state_next = out_free ? S_IDLE : S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Id counter: bumped on append, restarted on clear
    always_comb
    begin
        next_ident_next = next_ident_reg;
        if (finish)
        begin
            if (item_reg.command == wrmt_pkg::CMD_CLEAR)
            begin
                next_ident_next = 32'd1;
            end
            else if (tok_w[TABLE_ENTRIES].inserted)
            begin
                next_ident_next = next_ident_reg + 32'd1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_reg      <= 1'b0;
            next_ident_reg <= 32'd1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= accept;
            next_ident_reg <= next_ident_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command         <= command;
            item_reg.space           <= space;
            item_reg.address         <= address;
            item_reg.length          <= (length == 32'd0) ? 32'd1 : length;
            item_reg.access_mask     <= access_mask;
            item_reg.access_is_write <= access_is_write;
            item_reg.entry_id        <= entry_id;
            item_reg.enable_value    <= enable_value;
            item_reg.next_ident      <= 32'd0;
        end
        if (finish)
        begin
            pend_reg <= fin;
        end
        if (load_out)
        begin
            out_reg <= (state_reg == S_DRAIN) ? pend_reg : fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign result_id   = out_reg.rid;
    assign match_count = out_reg.hits;

endmodule

`default_nettype wire

FILE: hw/rtl/wrmt_checker.sv
// ----------------------------------------------------------------------------
// wrmt_checker: port-level checks for the watchpoint range match table
// Watches the top level's channels and result fields; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wrmt_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire [2:0]  command,
    input wire [7:0]  space,
    input wire [31:0] address,
    input wire [31:0] length,
    input wire [1:0]  access_mask,
    input wire        access_is_write,
    input wire [31:0] entry_id,
    input wire        enable_value,
    input wire        out_valid,
    input wire        out_ready,
    input wire [1:0]  status,
    input wire [31:0] result_id,
    input wire [31:0] match_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
        && $stable(result_id) && $stable(match_count))
        else $error("result changed while stalled");

    // Only one command in flight: no accept straight after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while a command is in flight");

    // Misses and full give zero id and count
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != wrmt_pkg::ST_DONE) |-> (result_id == 32'd0)
        && (match_count == 32'd0))
        else $error("non-zero id or count on a failed command");

    // A counted hit always names an entry
    a_hit_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (match_count != 32'd0) |-> (result_id != 32'd0))
        else $error("hit count without an entry id");

    // No undefined status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == wrmt_pkg::ST_DONE) || (status == wrmt_pkg::ST_MISS)
        || (status == wrmt_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind watchpoint_range_match_table wrmt_checker u_wrmt_checker (.*);

`default_nettype wire
